@@ rtl/bale_pkg.sv @@
// Shared constants, operation and status codes, and controller/datapath
// command and status structs for the bounded array list engine.
// No dependencies.
`default_nettype none

package bale_pkg;

    // List sizing
    localparam int CAPACITY  = 8;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Field widths
    localparam int OP_W      = 4;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 8;
    localparam int FIDX_W    = 6;
    localparam int STAT_W    = 3;

    // Stream bus widths (whole bytes)
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 40;

    // Remainder unit: dividend bits consumed per cycle
    localparam int REM_BITS  = 4;
    localparam int REM_STEPS = WORD_W / REM_BITS;
    localparam int REM_CNT_W = (REM_STEPS > 1) ? $clog2(REM_STEPS) : 1;

    // Request operations
    localparam logic [OP_W-1:0] OP_INS_FRONT = 4'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 4'd1;
    localparam logic [OP_W-1:0] OP_INS_AT    = 4'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 4'd3;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 4'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 4'd5;
    localparam logic [OP_W-1:0] OP_SEARCH    = 4'd6;
    localparam logic [OP_W-1:0] OP_LIST_ALL  = 4'd7;
    localparam logic [OP_W-1:0] OP_ROTATE    = 4'd8;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

    // Commands from controller to datapath
    typedef struct packed {
        logic              capture;     // latch the accepted request
        logic              ins;         // insert at the effective position
        logic              del_load;    // point the read index at the delete position
        logic              del_exec;    // take the word out and close the gap
        logic              rem_start;   // start rotate-count reduction
        logic              rot_step;    // rotate the filled part right by one
        logic              idx_inc;     // advance the read index
        logic              load;        // load the result register
        logic              load_entry;  // result word from the read port
        logic              load_idx;    // result index from the read index
        logic              load_last;
        logic [STAT_W-1:0] load_status;
    } bale_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            ins_bad;
        logic            del_bad;
        logic            neg_rot;
        logic            rem_busy;
        logic            rot_done;
        logic            hit;
        logic            scan_end;
        logic            out_free;
    } bale_stat_t;

endpackage

`default_nettype wire

@@ rtl/bale_rem.sv @@
// Remainder unit: reduces a 32-bit dividend modulo the fill count,
// REM_BITS dividend bits per cycle. Depends on bale_pkg.
`default_nettype none

module bale_rem
    import bale_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] dividend,
    input  wire logic [CNT_W-1:0]  divisor,
    output logic                   busy,
    output logic [CNT_W-1:0]       remainder
);

    logic                 busy_reg, busy_next;
    logic [REM_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]    dvd_reg, dvd_next;
    logic [CNT_W-1:0]     div_reg, div_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W:0]       acc;

    // Restoring remainder over one digit of REM_BITS bits
    always_comb begin
        acc = {1'b0, rem_reg};
        for (int k = 0; k < REM_BITS; k++) begin
            acc = {acc[CNT_W-1:0], dvd_reg[WORD_W-1-k]};
            if (acc >= {1'b0, div_reg}) begin
                acc = acc - {1'b0, div_reg};
            end
        end
    end

    // Load on start, then shift one digit a cycle until all are consumed
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = acc[CNT_W-1:0];
            dvd_next = dvd_reg << REM_BITS;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == REM_CNT_W'(REM_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/bale_dp.sv @@
// Datapath: request registers, list storage with shift network, read port,
// remainder unit and result register. Depends on bale_pkg and bale_rem.
`default_nettype none

module bale_dp
    import bale_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire bale_cmd_t         cmd,
    output bale_stat_t             stat,
    input  wire logic [OP_W-1:0]   in_op,
    input  wire logic [WORD_W-1:0] in_item_value,
    input  wire logic [POS_W-1:0]  in_position,
    input  wire logic [WORD_W-1:0] in_rotate_count,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [STAT_W-1:0]      out_status,
    output logic [WORD_W-1:0]      out_data_word,
    output logic [FIDX_W-1:0]      out_found_index,
    output logic                   out_last
);

    // Request registers
    logic [OP_W-1:0]   op_reg;
    logic [WORD_W-1:0] value_reg;
    logic [POS_W-1:0]  position_reg;
    logic [WORD_W-1:0] rc_reg;

    // List state
    logic [WORD_W-1:0] entries_reg  [CAPACITY];
    logic [WORD_W-1:0] entries_next [CAPACITY];
    logic [CNT_W-1:0]  fill_count_reg, fill_count_next;

    // Working registers
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  rot_cnt_reg, rot_cnt_next;
    logic [WORD_W-1:0] word_reg, word_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic [FIDX_W-1:0] out_index_reg;
    logic              out_last_reg;

    logic [CNT_W-1:0]  fill_m1;
    logic [POS_W-1:0]  ins_pos;
    logic [POS_W-1:0]  del_pos;
    logic [WORD_W-1:0] rd_word;
    logic              rem_busy;
    logic [CNT_W-1:0]  rem_val;
    logic              out_free;

    assign fill_m1  = fill_count_reg - 1'b1;
    assign rd_word  = entries_reg[idx_reg];
    assign out_free = !out_valid_reg || out_ready;

    // Resolve the effective insert and delete positions
    always_comb begin
        case (op_reg)
            OP_INS_FRONT: ins_pos = '0;
            OP_INS_BACK:  ins_pos = POS_W'(fill_count_reg);
            default:      ins_pos = position_reg;
        endcase
        case (op_reg)
            OP_DEL_FRONT: del_pos = '0;
            OP_DEL_BACK:  del_pos = POS_W'(fill_m1);
            default:      del_pos = position_reg;
        endcase
    end

    // Reduce the rotate count modulo the fill
    bale_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.rem_start),
        .dividend  (rc_reg),
        .divisor   (fill_count_reg),
        .busy      (rem_busy),
        .remainder (rem_val)
    );

    // Status back to the controller
    always_comb begin
        stat.op       = op_reg;
        stat.full     = (fill_count_reg == CNT_W'(CAPACITY));
        stat.empty    = (fill_count_reg == '0);
        stat.ins_bad  = (ins_pos > POS_W'(fill_count_reg));
        stat.del_bad  = (del_pos >= POS_W'(fill_count_reg));
        stat.neg_rot  = rc_reg[WORD_W-1];
        stat.rem_busy = rem_busy;
        stat.rot_done = (rot_cnt_reg == rem_val[IDX_W-1:0]);
        stat.hit      = (rd_word == value_reg);
        stat.scan_end = (CNT_W'(idx_reg) == fill_m1);
        stat.out_free = out_free;
    end

    // Shift network: insert opens a gap, delete closes one, rotate moves right
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            entries_next[i] = entries_reg[i];
        end
        if (cmd.ins) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (IDX_W'(i) == ins_pos[IDX_W-1:0]) begin
                    entries_next[i] = value_reg;
                end else if (i > 0 && IDX_W'(i) > ins_pos[IDX_W-1:0]) begin
                    entries_next[i] = entries_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end else if (cmd.del_exec) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (IDX_W'(i) >= idx_reg) begin
                    entries_next[i] = entries_reg[i + 1];
                end
            end
        end else if (cmd.rot_step) begin
            entries_next[0] = rd_word;
            for (int i = 1; i < CAPACITY; i++) begin
                entries_next[i] = entries_reg[i - 1];
            end
        end
    end

    // Fill count, read index, rotate counter and removed word
    always_comb begin
        fill_count_next = fill_count_reg;
        idx_next        = idx_reg;
        rot_cnt_next    = rot_cnt_reg;
        word_next       = word_reg;
        if (cmd.capture) begin
            idx_next  = '0;
            word_next = '0;
        end
        if (cmd.ins) begin
            fill_count_next = fill_count_reg + 1'b1;
        end
        if (cmd.del_load) begin
            idx_next = del_pos[IDX_W-1:0];
        end
        if (cmd.del_exec) begin
            word_next       = rd_word;
            fill_count_next = fill_count_reg - 1'b1;
        end
        if (cmd.rem_start) begin
            idx_next     = fill_m1[IDX_W-1:0];
            rot_cnt_next = '0;
        end
        if (cmd.rot_step) begin
            rot_cnt_next = rot_cnt_reg + 1'b1;
        end
        if (cmd.idx_inc) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    // Result register: hold until taken, refill when free
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            entries_reg[i] <= entries_next[i];
        end
        idx_reg     <= idx_next;
        rot_cnt_reg <= rot_cnt_next;
        word_reg    <= word_next;
        if (cmd.capture) begin
            op_reg       <= in_op;
            value_reg    <= in_item_value;
            position_reg <= in_position;
            rc_reg       <= in_rotate_count;
        end
        if (cmd.load) begin
            out_status_reg <= cmd.load_status;
            out_word_reg   <= cmd.load_entry ? rd_word : word_reg;
            out_index_reg  <= cmd.load_idx ? FIDX_W'(idx_reg) : '0;
            out_last_reg   <= cmd.load_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_data_word   = out_word_reg;
    assign out_found_index = out_index_reg;
    assign out_last        = out_last_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> out_free)
        else $error("result register loaded while a result is pending");

    a_ins_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins |=> fill_count_reg == $past(fill_count_reg) + 1'b1)
        else $error("insert did not grow the list by one");

    a_del_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.del_exec |-> fill_count_reg != '0 && CNT_W'(idx_reg) < fill_count_reg)
        else $error("delete outside the filled part");
`endif

endmodule

`default_nettype wire

@@ rtl/bale_ctrl.sv @@
// Controller state machine: sequences each request through checks, shifts,
// scans, rotate steps and result loads. Depends on bale_pkg.
`default_nettype none

module bale_ctrl
    import bale_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire bale_stat_t stat,
    output bale_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DEL  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_LIST = 3'd4;
    localparam logic [2:0] S_REM  = 3'd5;
    localparam logic [2:0] S_ROT  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [STAT_W-1:0] status_reg, status_next;

    assign req_ready = (state_reg == S_IDLE);

    // Next state, final status and datapath commands
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next  = S_EMIT;
                status_next = STAT_OK;
                case (stat.op)
                    OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                        if (stat.full) begin
                            status_next = STAT_FULL;
                        end else if (stat.ins_bad) begin
                            status_next = STAT_BADPOS;
                        end else begin
                            cmd.ins = 1'b1;
                        end
                    end
                    OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT: begin
                        if (stat.empty) begin
                            status_next = STAT_EMPTY;
                        end else if (stat.del_bad) begin
                            status_next = STAT_BADPOS;
                        end else begin
                            cmd.del_load = 1'b1;
                            state_next   = S_DEL;
                        end
                    end
                    OP_SEARCH: begin
                        if (stat.empty) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    OP_LIST_ALL: begin
                        if (stat.empty) begin
                            status_next = STAT_EMPTY;
                        end else begin
                            state_next = S_LIST;
                        end
                    end
                    OP_ROTATE: begin
                        if (stat.empty) begin
                            status_next = STAT_EMPTY;
                        end else if (!stat.neg_rot) begin
                            cmd.rem_start = 1'b1;
                            state_next    = S_REM;
                        end
                    end
                    default: begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            S_DEL: begin
                cmd.del_exec = 1'b1;
                state_next   = S_EMIT;
            end
            S_SCAN: begin
                // Walk entries from the front until a match or the end
                if (stat.hit) begin
                    status_next = STAT_OK;
                    state_next  = S_EMIT;
                end else if (stat.scan_end) begin
                    status_next = STAT_NOTFOUND;
                    state_next  = S_EMIT;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_LIST: begin
                // Emit one entry per free result slot
                if (stat.out_free) begin
                    cmd.load        = 1'b1;
                    cmd.load_entry  = 1'b1;
                    cmd.load_idx    = 1'b1;
                    cmd.load_last   = stat.scan_end;
                    cmd.load_status = STAT_OK;
                    if (stat.scan_end) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            S_REM: begin
                if (!stat.rem_busy) begin
                    state_next = S_ROT;
                end
            end
            S_ROT: begin
                if (stat.rot_done) begin
                    status_next = STAT_OK;
                    state_next  = S_EMIT;
                end else begin
                    cmd.rot_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.load        = 1'b1;
                    cmd.load_last   = 1'b1;
                    cmd.load_status = status_reg;
                    cmd.load_idx    = (stat.op == OP_SEARCH) && (status_reg == STAT_OK);
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
    end

`ifndef NO_ASSERTIONS
    a_rot_after_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ROT |-> !stat.rem_busy)
        else $error("rotate steps started before the count was reduced");

    a_one_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.ins, cmd.del_exec, cmd.rot_step}) <= 1)
        else $error("more than one list update in a cycle");

    a_load_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> stat.out_free)
        else $error("result issued with no free slot");
`endif

endmodule

`default_nettype wire

@@ rtl/bounded_array_list_engine.sv @@
// Bounded array list engine: an ordered list of up to CAPACITY signed words.
// Channels: s_* carries one request per handshake (op in s_tuser, operands in
// s_tdata); m_* returns result items (status in m_tuser, word and index in
// m_tdata, m_tlast on the final result of each request).
// Every request yields exactly one result, except list-all on a non-empty
// list, which yields one result per entry in index order.
// A search walks the list from the front, one entry compared per cycle, until
// a match or the end; a rotate first reduces the count in the remainder unit
// (4 count bits a cycle) and then takes r single-place rotate steps,
// r = count mod fill.
// Throughput: one request in flight at a time; s_tready rises once the final
// result sits in the output register, so the next request is taken while
// that result still waits.
// Reset: aresetn low for one clock empties the list and drops any result.
// A stalled m_tready holds the output register; a list-all run pauses with it.
`default_nettype none

module bounded_array_list_engine
    import bale_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // item_value[31:0], position[39:32],
                                                // rotate_count[71:40]
    input  wire logic [OP_W-1:0]      s_tuser,  // op[3:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,  // data_word[31:0], found_index[37:32],
                                                // zero fill [39:38]
    output logic [STAT_W-1:0]         m_tuser,  // status[2:0]
    output logic                      m_tlast
);

    bale_cmd_t         cmd;
    bale_stat_t        stat;
    logic [WORD_W-1:0] data_word;
    logic [FIDX_W-1:0] found_index;

    // Sequence requests
    bale_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the list and the result register
    bale_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (s_tuser),
        .in_item_value   (s_tdata[WORD_W-1:0]),
        .in_position     (s_tdata[WORD_W +: POS_W]),
        .in_rotate_count (s_tdata[WORD_W+POS_W +: WORD_W]),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_status      (m_tuser),
        .out_data_word   (data_word),
        .out_found_index (found_index),
        .out_last        (m_tlast)
    );

    // Pack the result word and index, zero-filled to whole bytes
    assign m_tdata = {{(M_TDATA_W - WORD_W - FIDX_W){1'b0}}, found_index, data_word};

endmodule

`default_nettype wire
